[hdl/scbcd_pkg.sv]
// ----------------------------------------------------------------------------
// scbcd_pkg: shared types and constants for the sample count to BCD core
// Holds the mixed-radix time digit type that moves along the cell chain.
// ----------------------------------------------------------------------------
package scbcd_pkg;

    localparam int unsigned DIGIT_W = 6;   // holds 0..59
    localparam int unsigned RADIX   = 60;

    typedef struct packed {
        logic [DIGIT_W-1:0] hr;
        logic [DIGIT_W-1:0] min;
        logic [DIGIT_W-1:0] sec;
    } hms_t;

endpackage

[hdl/sample_count_to_bcd_hms_core.sv]
// ----------------------------------------------------------------------------
// sample_count_to_bcd_hms_core: sample count to BCD hh:mm:ss
// Divides a sample count by the configured sample rate and shows the whole
// elapsed seconds as three two-digit BCD fields, each modulo 60.
// ----------------------------------------------------------------------------
// The core accepts one sample count per clock while the output is not stalled
// and returns one result per count, in order: a chain of COUNT_BITS cells
// each resolves one quotient bit of count / sample_rate and keeps the
// running seconds as mixed-radix digits, then an output register converts
// them to BCD. A stalled result holds the whole chain. sample_rate resets to
// 44100; a rate of zero gives all-zero fields. Write sample_rate only while
// no transaction is in flight.
module sample_count_to_bcd_hms_core #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned RATE_BITS  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [RATE_BITS-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_sample_count,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [6:0]            m_hours_bcd,
    output logic [6:0]            m_minutes_bcd,
    output logic [6:0]            m_seconds_bcd
);

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(44100);

    logic [RATE_BITS-1:0]  rate_reg;
    logic                  out_valid_reg;
    logic [6:0]            hours_reg, minutes_reg, seconds_reg;
    logic                  adv;

    logic                  ch_valid [COUNT_BITS+1];
    logic [RATE_BITS-1:0]  ch_rem   [COUNT_BITS+1];
    logic [COUNT_BITS-1:0] ch_cnt   [COUNT_BITS+1];
    scbcd_pkg::hms_t       ch_hms   [COUNT_BITS+1];

    // value 0..59 to two BCD digits; tens by reciprocal multiply
    function automatic logic [6:0] to_bcd2(input logic [scbcd_pkg::DIGIT_W-1:0] v);
        logic [9:0] prod;
        logic [2:0] tens;
        logic [6:0] tens_x10;
        logic [3:0] ones;
        prod     = 10'(v) * 10'd13;
        tens     = prod[9:7];
        tens_x10 = 7'(tens) * 7'd10;
        ones     = 4'(7'(v) - tens_x10);
        return {tens, ones};
    endfunction

    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || m_ready;
    assign s_ready   = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            rate_reg <= cfg_data;
        end
    end

    assign ch_valid[0] = s_valid;
    assign ch_rem[0]   = '0;
    assign ch_cnt[0]   = s_sample_count;
    assign ch_hms[0]   = '0;

    for (genvar i = 0; i < COUNT_BITS; i++) begin : g_cell
        scbcd_cell #(
            .COUNT_BITS (COUNT_BITS),
            .RATE_BITS  (RATE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .divisor   (rate_reg),
            .in_valid  (ch_valid[i]),
            .in_rem    (ch_rem[i]),
            .in_cnt    (ch_cnt[i]),
            .in_hms    (ch_hms[i]),
            .out_valid (ch_valid[i+1]),
            .out_rem   (ch_rem[i+1]),
            .out_cnt   (ch_cnt[i+1]),
            .out_hms   (ch_hms[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= ch_valid[COUNT_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hours_reg   <= to_bcd2(ch_hms[COUNT_BITS].hr);
            minutes_reg <= to_bcd2(ch_hms[COUNT_BITS].min);
            seconds_reg <= to_bcd2(ch_hms[COUNT_BITS].sec);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hours_bcd   = hours_reg;
    assign m_minutes_bcd = minutes_reg;
    assign m_seconds_bcd = seconds_reg;

endmodule

[hdl/scbcd_cell.sv]
// ----------------------------------------------------------------------------
// scbcd_cell: one stage of the divider chain
// Resolves one quotient bit by restoring division and folds it into a
// running hours/minutes/seconds value kept modulo 60 in each digit.
// ----------------------------------------------------------------------------
module scbcd_cell #(
    parameter int unsigned COUNT_BITS = 32,
    parameter int unsigned RATE_BITS  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic [RATE_BITS-1:0]  divisor,
    input  logic                  in_valid,
    input  logic [RATE_BITS-1:0]  in_rem,
    input  logic [COUNT_BITS-1:0] in_cnt,
    input  scbcd_pkg::hms_t       in_hms,
    output logic                  out_valid,
    output logic [RATE_BITS-1:0]  out_rem,
    output logic [COUNT_BITS-1:0] out_cnt,
    output scbcd_pkg::hms_t       out_hms
);

    localparam logic [scbcd_pkg::DIGIT_W:0] RADIX_W = (scbcd_pkg::DIGIT_W+1)'(scbcd_pkg::RADIX);

    logic                  valid_reg;
    logic [RATE_BITS-1:0]  rem_reg, rem_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    scbcd_pkg::hms_t       hms_reg, hms_next;

    logic [RATE_BITS:0]          trial;
    logic [RATE_BITS:0]          trial_sub;
    logic                        qbit;
    logic [scbcd_pkg::DIGIT_W:0] sec2, min2, hr2;
    logic                        c_sec, c_min, c_hr;

    always_comb begin
        trial     = {in_rem, in_cnt[COUNT_BITS-1]};
        // a zero rate yields a zero quotient
        qbit      = (divisor != '0) && (trial >= {1'b0, divisor});
        trial_sub = trial - {1'b0, divisor};
        rem_next  = qbit ? trial_sub[RATE_BITS-1:0] : trial[RATE_BITS-1:0];
        cnt_next  = {in_cnt[COUNT_BITS-2:0], 1'b0};

        // double the elapsed seconds and add the new bit, digit by digit
        sec2  = {in_hms.sec, qbit};
        c_sec = (sec2 >= RADIX_W);
        min2  = {in_hms.min, c_sec};
        c_min = (min2 >= RADIX_W);
        hr2   = {in_hms.hr, c_min};
        c_hr  = (hr2 >= RADIX_W);

        hms_next.sec = c_sec ? scbcd_pkg::DIGIT_W'(sec2 - RADIX_W)
                             : sec2[scbcd_pkg::DIGIT_W-1:0];
        hms_next.min = c_min ? scbcd_pkg::DIGIT_W'(min2 - RADIX_W)
                             : min2[scbcd_pkg::DIGIT_W-1:0];
        // drop the carry out of hours: they wrap at 60
        hms_next.hr  = c_hr  ? scbcd_pkg::DIGIT_W'(hr2 - RADIX_W)
                             : hr2[scbcd_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            hms_reg <= hms_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_cnt   = cnt_reg;
    assign out_hms   = hms_reg;

endmodule

[hdl/scbcd_checker.sv]
// ----------------------------------------------------------------------------
// scbcd_checker: port-level checks for the sample count to BCD core
// Watches the handshakes at the top level and is bound to it.
// ----------------------------------------------------------------------------
module scbcd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_hours_bcd,
    input logic [6:0] m_minutes_bcd,
    input logic [6:0] m_seconds_bcd
);

    // the input side advances exactly when the output slot is free or draining
    a_ready_tracks_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow the output slot");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction dropped while stalled");

    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hours_bcd) && $stable(m_minutes_bcd)
                                && $stable(m_seconds_bcd))
        else $error("stalled result changed");

endmodule

bind sample_count_to_bcd_hms_core scbcd_checker u_scbcd_checker (.*);
